// File: src/multi_channel_step_pulse_generator_assert.svh
`ifndef MULTI_CHANNEL_STEP_PULSE_GENERATOR_ASSERT_SVH
`define MULTI_CHANNEL_STEP_PULSE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MCSPG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcspg assertion failed");

// next-cycle implication
`define MCSPG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcspg assertion failed");

`endif

// File: src/mcspg_pkg.sv
package mcspg_pkg;

   localparam int DIV_W   = 28;
   localparam int STEP_W  = 32;
   localparam int MASK_W  = 8;
   localparam int KIND_W  = 2;
   localparam int CHAN_W  = 3;

   localparam logic [DIV_W-1:0] CLOCK_RESET = 28'd125000000;

   localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_result_type;

   typedef struct packed {
      logic pulse;
      logic finished;
      logic halt;
   } tick_flags_type;

endpackage

// File: src/multi_channel_step_pulse_generator.sv
// Multi-channel step pulse generator.
// Input channel req_*: one transaction per item. kind tick advances every
// running channel by one clock; kind run loads a channel with a rate and a
// step count; kind stop idles a channel. Every transaction yields exactly one
// rsp_* transaction: step levels for a tick (zero otherwise), the busy mask
// after the item and the channels that finished on a tick.
// csr_*: writes the system clock frequency; always ready, write only when idle.
// A tick walks the channels in order, one channel per cycle, through the shared
// tick unit; a run with nonzero rate and count waits on the bit-serial period
// divider; stop and ignored items go straight to the done state.
// req_ready is high only between items, so a new item is not taken before
// the last one has moved on into the output register.
// A finished transaction sits in an output register; the next item is taken
// while it waits. If rsp_ready stays low, the following item holds its
// result until the register frees, and req_ready stays low meanwhile.
// Reset idles all channels, empties the output register and restores the
// clock frequency to 125 MHz.
module multi_channel_step_pulse_generator import mcspg_pkg::*; #(
   parameter int NUM_CHANNELS = 8,
   parameter int PERIOD_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [CHAN_W-1:0] req_channel,
   input  logic [DIV_W-1:0]  req_freq_hz,
   input  logic [STEP_W-1:0] req_step_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [MASK_W-1:0] rsp_step_pulses,
   output logic [MASK_W-1:0] rsp_busy_mask,
   output logic [MASK_W-1:0] rsp_finished_mask,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [DIV_W-1:0]  csr_sys_clock_hz
);

   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int IDX_W = (CH_W > CHAN_W) ? CH_W : CHAN_W;
   localparam int PAD_W = (NUM_CHANNELS > MASK_W) ? NUM_CHANNELS : MASK_W;
   localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);
   localparam logic [32:0] PERIOD_MAX = (33'd1 << PERIOD_BITS) - 33'd1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TICK = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [CH_W-1:0]         idx_ff, idx_in;
   logic [CH_W-1:0]         run_ch_ff, run_ch_in;
   logic [STEP_W-1:0]       run_steps_ff, run_steps_in;
   logic [DIV_W-1:0]        clock_hz_ff;
   logic [NUM_CHANNELS-1:0] running_ff, running_in;
   logic [NUM_CHANNELS-1:0] pulse_acc_ff, pulse_acc_in;
   logic [NUM_CHANNELS-1:0] fin_acc_ff, fin_acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]       rsp_pulse_ff, rsp_pulse_in;
   logic [MASK_W-1:0]       rsp_busy_ff, rsp_busy_in;
   logic [MASK_W-1:0]       rsp_fin_ff, rsp_fin_in;

   logic [PERIOD_BITS-1:0]  period_ff  [NUM_CHANNELS];
   logic [PERIOD_BITS-1:0]  high_ff    [NUM_CHANNELS];
   logic [PERIOD_BITS-1:0]  counter_ff [NUM_CHANNELS];
   logic [STEP_W-1:0]       steps_ff   [NUM_CHANNELS];

   logic [IDX_W-1:0]        ch_wide;
   logic [CH_W-1:0]         ch_idx;
   logic                    ch_ok;
   logic                    run_ok;
   logic                    div_start;
   div_result_type          div_res;

   logic [PERIOD_BITS-1:0]  tick_counter_in;
   logic [STEP_W-1:0]       tick_steps_in;
   tick_flags_type          tick_flags;

   logic [DIV_W-1:0]        q_min;
   logic [32:0]             q_wide;
   logic [32:0]             period_sat;
   logic [PERIOD_BITS-1:0]  period_new;

   logic [PAD_W-1:0]        pulse_pad;
   logic [PAD_W-1:0]        busy_pad;
   logic [PAD_W-1:0]        fin_pad;

   assign ch_wide = IDX_W'(req_channel);
   assign ch_idx  = ch_wide[CH_W-1:0];
   assign ch_ok   = 32'(req_channel) < 32'(NUM_CHANNELS);
   assign run_ok  = ch_ok && (req_freq_hz != '0) && (req_step_count != '0);

   mcspg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clock_hz_ff),
      .divisor  (req_freq_hz),
      .result   (div_res)
   );

   mcspg_tick_unit #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_tick (
      .phase_counter    (counter_ff[idx_ff]),
      .high_time        (high_ff[idx_ff]),
      .period           (period_ff[idx_ff]),
      .steps_left       (steps_ff[idx_ff]),
      .phase_counter_in (tick_counter_in),
      .steps_left_in    (tick_steps_in),
      .flags            (tick_flags)
   );

   // period = max(q, 2) - 1, saturated
   assign q_min      = (div_res.quotient < DIV_W'(2)) ? DIV_W'(2) : div_res.quotient;
   assign q_wide     = 33'(q_min - DIV_W'(1));
   assign period_sat = (q_wide > PERIOD_MAX) ? PERIOD_MAX : q_wide;
   assign period_new = period_sat[PERIOD_BITS-1:0];

   assign pulse_pad = PAD_W'(pulse_acc_ff);
   assign busy_pad  = PAD_W'(running_ff);
   assign fin_pad   = PAD_W'(fin_acc_ff);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      run_ch_in    = run_ch_ff;
      run_steps_in = run_steps_ff;
      running_in   = running_ff;
      pulse_acc_in = pulse_acc_ff;
      fin_acc_in   = fin_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_busy_in  = rsp_busy_ff;
      rsp_fin_in   = rsp_fin_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pulse_acc_in = '0;
               fin_acc_in   = '0;
               state_in     = ST_DONE;
               unique case (req_kind)
                  KIND_TICK: begin
                     idx_in   = '0;
                     state_in = ST_TICK;
                  end
                  KIND_RUN: begin
                     if (run_ok) begin
                        div_start    = 1'b1;
                        run_ch_in    = ch_idx;
                        run_steps_in = req_step_count;
                        state_in     = ST_DIV;
                     end
                  end
                  KIND_STOP: begin
                     if (ch_ok) begin
                        running_in[ch_idx] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (running_ff[idx_ff]) begin
               pulse_acc_in[idx_ff] = tick_flags.pulse;
               fin_acc_in[idx_ff]   = tick_flags.finished;
               if (tick_flags.halt) begin
                  running_in[idx_ff] = 1'b0;
               end
            end
            if (idx_ff == CH_LAST) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + CH_W'(1);
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               running_in[run_ch_ff] = 1'b1;
               state_in              = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pulse_in = pulse_pad[MASK_W-1:0];
               rsp_busy_in  = busy_pad[MASK_W-1:0];
               rsp_fin_in   = fin_pad[MASK_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         clock_hz_ff  <= CLOCK_RESET;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            clock_hz_ff <= csr_sys_clock_hz;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      run_ch_ff    <= run_ch_in;
      run_steps_ff <= run_steps_in;
      pulse_acc_ff <= pulse_acc_in;
      fin_acc_ff   <= fin_acc_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_busy_ff  <= rsp_busy_in;
      rsp_fin_ff   <= rsp_fin_in;
      if (state_ff == ST_TICK && running_ff[idx_ff]) begin
         counter_ff[idx_ff] <= tick_counter_in;
         steps_ff[idx_ff]   <= tick_steps_in;
      end else if (state_ff == ST_DIV && div_res.done) begin
         period_ff[run_ch_ff]  <= period_new;
         high_ff[run_ch_ff]    <= period_new >> 1;
         counter_ff[run_ch_ff] <= '0;
         steps_ff[run_ch_ff]   <= run_steps_ff;
      end
   end

   assign req_ready         = state_ff == ST_IDLE;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_pulses   = rsp_pulse_ff;
   assign rsp_busy_mask     = rsp_busy_ff;
   assign rsp_finished_mask = rsp_fin_ff;

endmodule

// File: src/mcspg_div.sv
module mcspg_div import mcspg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output div_result_type   result
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;

   logic [DIV_W:0]   shifted;
   logic [DIV_W+1:0] diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign ge      = !diff[DIV_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

// File: src/mcspg_tick_unit.sv
module mcspg_tick_unit import mcspg_pkg::*; #(
   parameter int PERIOD_BITS = 16
) (
   input  logic [PERIOD_BITS-1:0] phase_counter,
   input  logic [PERIOD_BITS-1:0] high_time,
   input  logic [PERIOD_BITS-1:0] period,
   input  logic [STEP_W-1:0]      steps_left,
   output logic [PERIOD_BITS-1:0] phase_counter_in,
   output logic [STEP_W-1:0]      steps_left_in,
   output tick_flags_type         flags
);

   logic wrap;
   logic last_step;
   logic no_steps;

   assign wrap      = phase_counter >= period;
   assign last_step = steps_left == STEP_W'(1);
   assign no_steps  = steps_left == '0;

   assign phase_counter_in = wrap ? '0 : phase_counter + PERIOD_BITS'(1);
   assign steps_left_in    = (wrap && !no_steps) ? steps_left - STEP_W'(1) : steps_left;

   assign flags.pulse    = phase_counter < high_time;
   assign flags.finished = wrap && last_step;
   assign flags.halt     = wrap && (last_step || no_steps);

endmodule

// File: src/mcspg_checker.sv
`include "multi_channel_step_pulse_generator_assert.svh"

module mcspg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_step_pulses,
   input logic [7:0] rsp_busy_mask,
   input logic [7:0] rsp_finished_mask
);

   `MCSPG_ASSERT_IMP(a_finished_not_busy, clock, reset, rsp_valid, (rsp_finished_mask & rsp_busy_mask) == 8'd0)

   `MCSPG_ASSERT_NXT(a_one_item_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   `MCSPG_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_step_pulses) && $stable(rsp_busy_mask) && $stable(rsp_finished_mask))

   `MCSPG_ASSERT_IMP(a_rsp_empty_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind multi_channel_step_pulse_generator mcspg_checker u_checker (.*);

// File: sim/multi_channel_step_pulse_generator_tb.sv
`timescale 1ns / 100ps

module multi_channel_step_pulse_generator_tb;
   import mcspg_pkg::*;

   localparam int NUM_CH = 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 221;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [15:0] PERIOD_MAX = 16'hFFFF;
   localparam logic [DIV_W-1:0] CLOCK_MAX = 28'hFFFFFFF;

   typedef struct packed {
      logic [MASK_W-1:0] step_pulses;
      logic [MASK_W-1:0] busy_mask;
      logic [MASK_W-1:0] finished_mask;
   } step_result_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAN_W-1:0] channel;
      logic [DIV_W-1:0]  freq_hz;
      logic [STEP_W-1:0] step_count;
   } step_request_type;

   class pulse_scoreboard;
      logic [DIV_W-1:0]  sys_clock;
      logic [15:0]       period [NUM_CH];
      logic [15:0]       high_time [NUM_CH];
      logic [15:0]       phase [NUM_CH];
      logic [STEP_W-1:0] steps_left [NUM_CH];
      logic [NUM_CH-1:0] running;
      step_result_type   expected_levels [$];
      int                failures;
      int                checked;
      int                ticks;
      int                runs;
      int                stops;
      int                completions;
      int                clock_writes;

      function new();
         sys_clock = CLOCK_RESET;
         running = '0;
         for (int c = 0; c < NUM_CH; c++) begin
            period[c] = '0;
            high_time[c] = '0;
            phase[c] = '0;
            steps_left[c] = '0;
         end
      endfunction

      function void write_clock(logic [DIV_W-1:0] value);
         sys_clock = value;
         clock_writes++;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      function void note_request(step_request_type req);
         step_result_type res;
         logic [DIV_W-1:0] quo;
         res = '0;
         case (req.kind)
            KIND_TICK: begin
               ticks++;
               for (int c = 0; c < NUM_CH; c++) begin
                  if (running[c]) begin
                     if (phase[c] < high_time[c]) res.step_pulses[c] = 1'b1;
                     if (phase[c] >= period[c]) begin
                        phase[c] = '0;
                        if (steps_left[c] != 0) begin
                           steps_left[c] = steps_left[c] - 1;
                           if (steps_left[c] == 0) begin
                              running[c] = 1'b0;
                              res.finished_mask[c] = 1'b1;
                              completions++;
                           end
                        end else begin
                           running[c] = 1'b0;
                        end
                     end else begin
                        phase[c] = phase[c] + 16'd1;
                     end
                  end
               end
            end
            KIND_RUN: begin
               if (req.freq_hz != 0 && req.step_count != 0) begin
                  runs++;
                  quo = sys_clock / req.freq_hz;
                  if (quo < 2) quo = 2;
                  quo = quo - 1;
                  period[req.channel] = (quo > PERIOD_MAX) ? PERIOD_MAX : quo[15:0];
                  high_time[req.channel] = period[req.channel] >> 1;
                  phase[req.channel] = '0;
                  steps_left[req.channel] = req.step_count;
                  running[req.channel] = 1'b1;
               end
            end
            KIND_STOP: begin
               stops++;
               steps_left[req.channel] = '0;
               running[req.channel] = 1'b0;
            end
            default: ;
         endcase
         res.busy_mask = running;
         expected_levels.push_back(res);
      endfunction

      function void check_response(step_result_type got);
         step_result_type exp;
         checked++;
         if (expected_levels.size() == 0) begin
            $error("unexpected rsp transaction: pulses %h busy %h finished %h",
                   got.step_pulses, got.busy_mask, got.finished_mask);
            failures++;
            return;
         end
         exp = expected_levels.pop_front();
         if (got.step_pulses !== exp.step_pulses) begin
            $error("step_pulses: expected %h, actual %h", exp.step_pulses, got.step_pulses);
            failures++;
         end
         if (got.busy_mask !== exp.busy_mask) begin
            $error("busy_mask: expected %h, actual %h", exp.busy_mask, got.busy_mask);
            failures++;
         end
         if (got.finished_mask !== exp.finished_mask) begin
            $error("finished_mask: expected %h, actual %h",
                   exp.finished_mask, got.finished_mask);
            failures++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [KIND_W-1:0] req_kind;
   logic [CHAN_W-1:0] req_channel;
   logic [DIV_W-1:0]  req_freq_hz;
   logic [STEP_W-1:0] req_step_count;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [MASK_W-1:0] rsp_step_pulses;
   logic [MASK_W-1:0] rsp_busy_mask;
   logic [MASK_W-1:0] rsp_finished_mask;
   logic              csr_valid;
   logic              csr_ready;
   logic [DIV_W-1:0]  csr_sys_clock_hz;

   pulse_scoreboard   sb;
   int                tx_idle_pct = 0;
   int                rx_idle_pct = 0;
   bit                hold_pending = 1'b0;
   int                quiet_cycles = 0;
   logic [DIV_W-1:0]  cur_clock = CLOCK_RESET;

   multi_channel_step_pulse_generator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_channel       (req_channel),
      .req_freq_hz       (req_freq_hz),
      .req_step_count    (req_step_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_step_pulses   (rsp_step_pulses),
      .rsp_busy_mask     (rsp_busy_mask),
      .rsp_finished_mask (rsp_finished_mask),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_sys_clock_hz  (csr_sys_clock_hz)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_clock(csr_sys_clock_hz);
         if (req_valid && req_ready)
            sb.note_request({req_kind, req_channel, req_freq_hz, req_step_count});
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_step_pulses, rsp_busy_mask, rsp_finished_mask});
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, plus one long hold-off to back up the block
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_pending = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_request(input step_request_type req);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= req.kind;
      req_channel    <= req.channel;
      req_freq_hz    <= req.freq_hz;
      req_step_count <= req.step_count;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send(input logic [KIND_W-1:0] kind, input int chan,
                       input logic [DIV_W-1:0] freq, input logic [STEP_W-1:0] count);
      send_request({kind, CHAN_W'(chan), freq, count});
   endtask

   task automatic write_clock(input logic [DIV_W-1:0] value);
      csr_valid        <= 1'b1;
      csr_sys_clock_hz <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_clock = value;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic step_request_type random_request();
      step_request_type req;
      int unsigned      pick;
      logic [31:0]      wide;
      req.channel    = CHAN_W'($urandom_range(NUM_CH - 1));
      req.freq_hz    = DIV_W'($urandom);
      req.step_count = $urandom;
      pick = $urandom_range(99);
      if (pick < 64) begin
         req.kind = KIND_TICK;
      end else if (pick < 84) begin
         req.kind = KIND_RUN;
         pick = $urandom_range(99);
         if (pick < 60) begin
            req.freq_hz = cur_clock / DIV_W'($urandom_range(2, 40));
            if (req.freq_hz == 0) req.freq_hz = DIV_W'($urandom_range(1, 3));
         end else if (pick < 85) begin
            wide = 32'(cur_clock) + $urandom_range(1, 1000);
            req.freq_hz = (wide > 32'(CLOCK_MAX)) ? CLOCK_MAX : wide[DIV_W-1:0];
         end else if (pick < 92) begin
            req.freq_hz = DIV_W'($urandom_range(1, 20));
         end else if (pick < 96) begin
            req.freq_hz = '0;
         end
         pick = $urandom_range(99);
         if (pick < 75) req.step_count = $urandom_range(1, 6);
         else if (pick < 90) req.step_count = $urandom_range(7, 40);
         else if (pick < 96) req.step_count = $urandom;
         else req.step_count = '0;
      end else if (pick < 96) begin
         req.kind = KIND_STOP;
      end else begin
         req.kind = KIND_UNUSED;
      end
      return req;
   endfunction

   task automatic run_directed();
      send(KIND_TICK, 0, '0, '0);
      send(KIND_RUN, 0, 28'd31250000, 32'd2);
      send(KIND_RUN, 7, CLOCK_MAX, 32'd1);
      send(KIND_RUN, 3, '0, 32'd5);
      send(KIND_RUN, 4, 28'd1000, '0);
      send(KIND_RUN, 5, 28'd1, 32'hFFFFFFFF);
      send(KIND_RUN, 1, 28'd62500000, 32'd3);
      repeat (8) send(KIND_TICK, 0, '0, '0);
      // restart of channel 0 after it has finished its steps
      send(KIND_RUN, 0, 28'd25000000, 32'd1);
      send(KIND_STOP, 2, '0, '0);
      send(KIND_UNUSED, 7, CLOCK_MAX, 32'hFFFFFFFF);
      repeat (3) send(KIND_TICK, 7, CLOCK_MAX, 32'hFFFFFFFF);
      send(KIND_STOP, 5, '0, '0);
      send(KIND_STOP, 7, '0, '0);
      repeat (2) send(KIND_TICK, 0, '0, '0);
   endtask

   initial begin
      logic [DIV_W-1:0] clocks [6];
      sb = new();
      clocks[0] = CLOCK_MAX;
      clocks[1] = 28'd1;
      clocks[2] = '0;
      clocks[3] = 28'd1000;
      clocks[4] = CLOCK_RESET;
      clocks[5] = DIV_W'($urandom);
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_kind         <= KIND_TICK;
      req_channel      <= '0;
      req_freq_hz      <= '0;
      req_step_count   <= '0;
      csr_valid        <= 1'b0;
      csr_sys_clock_hz <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      for (int p = 0; p < 6; p++) begin
         wait_drain();
         write_clock(clocks[p]);
         case (p % 3)
            0: begin
               tx_idle_pct = 30;
               rx_idle_pct = 63;
            end
            1: begin
               tx_idle_pct = 63;
               rx_idle_pct = 30;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         if (p == 2) hold_pending = 1'b1;
         repeat (ITEMS_PER_PHASE) send_request(random_request());
      end
      wait_drain();

      $display("Checked %0d transactions: %0d ticks, %0d loaded runs, %0d stops",
               sb.checked, sb.ticks, sb.runs, sb.stops);
      $display("%0d completions, %0d clock rewrites incl. zero and full scale, one long stall",
               sb.completions, sb.clock_writes);
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
